// ===== sv/crc8fr_pkg.sv =====
package crc8fr_pkg;

  localparam int BodyLen   = 23;
  localparam int StoreLen  = BodyLen - 1;
  localparam int StoreBits = StoreLen * 8;

  localparam logic [4:0] LAST_COUNT = 5'(BodyLen);
  localparam logic [7:0] CRC_POLY   = 8'h07;

  localparam logic [7:0] DEVICE_ID_RST = 8'd2;
  localparam logic [7:0] SOF_BYTE_RST  = 8'hAA;

  typedef enum logic [0:0] {
    CFG_DEVICE_ID = 1'b0,
    CFG_SOF_BYTE  = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_CRC_BAD  = 2'd1,
    ST_OTHER_ID = 2'd2,
    ST_CONTENT  = 2'd3
  } status_t;

  // Collected frame, handed over with the CRC byte.
  typedef struct packed {
    logic                 done;
    logic [StoreBits-1:0] body;
    logic [7:0]           rx_crc;
    logic [7:0]           calc_crc;
  } frame_t;

  typedef struct packed {
    logic [7:0]  computed_crc;
    logic [7:0]  received_crc;
    logic [31:0] level_bits;
    logic [31:0] fader_bits;
    logic [31:0] peak_bits;
    logic [7:0]  flag_bits;
    logic [63:0] track_name;
    logic [7:0]  frame_id;
  } result_t;

  // One CRC-8 byte step, MSB first.
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ===== sv/crc8_frame_receiver.sv =====
// The result request is presented in the cycle after the CRC byte is accepted.
// Throughput: one byte per cycle; the running CRC takes one unrolled byte step per cycle.
// The input stalls only when the CRC byte of a frame arrives while the previous
// result is still held in the output register; other bytes keep flowing.
// Reset: rst_n is synchronous, active low; it drops any partial frame and the
// pending result and restores device_id 2 and the start-of-frame byte 0xAA.
module crc8_frame_receiver
  import crc8fr_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  // Byte stream from the bus receiver.
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,     // [7:0] rx_byte
  // Checked frames.
  output logic         out_tvalid,
  input  logic         out_tready,
  // [7:0] frame_id, [71:8] track_name, [79:72] flag_bits, [111:80] peak_bits,
  // [143:112] fader_bits, [175:144] level_bits, [183:176] received_crc,
  // [191:184] computed_crc
  output logic [191:0] out_tdata,
  output logic [1:0]   out_tuser,    // [1:0] status
  // Register writes.
  input  logic         cfg_we,
  input  logic [0:0]   cfg_addr,
  input  logic [7:0]   cfg_wdata
);

  logic [7:0] device_id_r, device_id_nxt;
  logic [7:0] sof_byte_r, sof_byte_nxt;
  logic       byte_acc;
  logic       last_pending;
  frame_t     frame;
  status_t    res_status;
  result_t    res;

  // Register file: a write lands on the edge that carries it.
  always_comb begin
    device_id_nxt = device_id_r;
    sof_byte_nxt  = sof_byte_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_DEVICE_ID: device_id_nxt = cfg_wdata;
        CFG_SOF_BYTE:  sof_byte_nxt  = cfg_wdata;
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_id_r <= DEVICE_ID_RST;
      sof_byte_r  <= SOF_BYTE_RST;
    end else begin
      device_id_r <= device_id_nxt;
      sof_byte_r  <= sof_byte_nxt;
    end
  end

  // Hold the CRC byte only if the output register cannot make room for it.
  assign in_tready = !(last_pending && out_tvalid && !out_tready);
  assign byte_acc  = in_tvalid && in_tready;

  crc8fr_collect u_collect (
    .clk          (clk),
    .rst_n        (rst_n),
    .byte_acc     (byte_acc),
    .rx_byte      (in_tdata),
    .sof_byte     (sof_byte_r),
    .last_pending (last_pending),
    .frame        (frame)
  );

  crc8fr_check u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .frame      (frame),
    .device_id  (device_id_r),
    .res_ready  (out_tready),
    .res_valid  (out_tvalid),
    .res_status (res_status),
    .res        (res)
  );

  assign out_tdata = res;
  assign out_tuser = res_status;

endmodule

// ===== sv/crc8fr_collect.sv =====
module crc8fr_collect
  import crc8fr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       byte_acc,
  input  logic [7:0] rx_byte,
  input  logic [7:0] sof_byte,
  output logic       last_pending,
  output frame_t     frame
);

  logic                 in_frame_r,   in_frame_nxt;
  logic [4:0]           byte_count_r, byte_count_nxt;
  logic [7:0]           crc_r,        crc_nxt;
  logic [StoreBits-1:0] body_r,       body_nxt;
  logic                 shift_en;

  assign last_pending = in_frame_r && (byte_count_r == LAST_COUNT);

  always_comb begin
    in_frame_nxt   = in_frame_r;
    byte_count_nxt = byte_count_r;
    crc_nxt        = crc_r;
    shift_en       = 1'b0;
    if (byte_acc) begin
      if (!in_frame_r) begin
        if (rx_byte == sof_byte) begin
          in_frame_nxt   = 1'b1;
          byte_count_nxt = 5'd1;
          crc_nxt        = crc8_step(8'd0, rx_byte);
          shift_en       = 1'b1;
        end
      end else if (byte_count_r != LAST_COUNT) begin
        byte_count_nxt = byte_count_r + 5'd1;
        crc_nxt        = crc8_step(crc_r, rx_byte);
        shift_en       = 1'b1;
      end else begin
        in_frame_nxt   = 1'b0;
        byte_count_nxt = 5'd0;
        crc_nxt        = 8'd0;
      end
    end
  end

  // The start byte falls off the end; byte 1 lands in the low byte.
  assign body_nxt = {rx_byte, body_r[StoreBits-1:8]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r   <= 1'b0;
      byte_count_r <= 5'd0;
      crc_r        <= 8'd0;
    end else begin
      in_frame_r   <= in_frame_nxt;
      byte_count_r <= byte_count_nxt;
      crc_r        <= crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      body_r <= body_nxt;
    end
  end

  assign frame.done     = byte_acc && last_pending;
  assign frame.body     = body_r;
  assign frame.rx_crc   = rx_byte;
  assign frame.calc_crc = crc_r;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    byte_count_r <= LAST_COUNT)
    else $error("byte count beyond frame length");

  a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
    !in_frame_r |-> (byte_count_r == 5'd0))
    else $error("byte count nonzero while idle");

  a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
    frame.done |=> (!in_frame_r && crc_r == 8'd0))
    else $error("frame not closed after CRC byte");
`endif

endmodule

// ===== sv/crc8fr_check.sv =====
module crc8fr_check
  import crc8fr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  frame_t     frame,
  input  logic [7:0] device_id,
  input  logic       res_ready,
  output logic       res_valid,
  output status_t    res_status,
  output result_t    res
);

  logic    valid_r, valid_nxt;
  status_t status_r, status_nxt;
  result_t res_r, res_nxt;
  logic    floats_ok, names_ok;

  function automatic logic float_ok(input logic [31:0] bits);
    logic [31:0] mag;
    mag = {1'b0, bits[30:0]};
    if (mag > 32'h7F80_0000) begin
      return 1'b1;
    end else if (bits[31]) begin
      return mag == 32'd0;
    end
    return bits <= 32'h3F80_0000;
  endfunction

  always_comb begin
    res_nxt.frame_id     = frame.body[7:0];
    res_nxt.track_name   = frame.body[71:8];
    res_nxt.flag_bits    = frame.body[79:72];
    res_nxt.peak_bits    = frame.body[111:80];
    res_nxt.fader_bits   = frame.body[143:112];
    res_nxt.level_bits   = frame.body[175:144];
    res_nxt.received_crc = frame.rx_crc;
    res_nxt.computed_crc = frame.calc_crc;
  end

  always_comb begin
    names_ok = 1'b1;
    for (int i = 0; i < 8; i++) begin
      if (res_nxt.track_name[i*8 +: 8] != 8'd0 &&
          (res_nxt.track_name[i*8 +: 8] < 8'd32 || res_nxt.track_name[i*8 +: 8] > 8'd126)) begin
        names_ok = 1'b0;
      end
    end
    floats_ok = float_ok(res_nxt.peak_bits) && float_ok(res_nxt.fader_bits) &&
                float_ok(res_nxt.level_bits);
    if (frame.rx_crc != frame.calc_crc) begin
      status_nxt = ST_CRC_BAD;
    end else if (res_nxt.frame_id != device_id) begin
      status_nxt = ST_OTHER_ID;
    end else if (floats_ok && names_ok) begin
      status_nxt = ST_ACCEPTED;
    end else begin
      status_nxt = ST_CONTENT;
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (valid_r && res_ready) begin
      valid_nxt = 1'b0;
    end
    if (frame.done) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (frame.done) begin
      status_r <= status_nxt;
      res_r    <= res_nxt;
    end
  end

  assign res_valid  = valid_r;
  assign res_status = status_r;
  assign res        = res_r;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    frame.done |-> (!valid_r || res_ready))
    else $error("result overwritten before it was taken");

  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    frame.done |=> valid_r)
    else $error("completed frame gave no result");
`endif

endmodule
